/* src/assert_macros.svh */
// Assertion helpers shared by the checker RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TSC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/tsc_pkg.sv */
// Shared types and constants of the transport stream continuity checker.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
package tsc_pkg;

  localparam logic [7:0] SYNC_BYTE        = 8'h47;
  localparam int         ERR_BIT_POS      = 7;
  localparam int         PID_W            = 13;
  localparam int         TABLE_DEPTH      = 2 ** PID_W;
  localparam logic [PID_W-1:0] NULL_PID   = 13'h1FFF;
  localparam int         CC_FIELD_W       = 5;
  localparam int         PAYLOAD_FLAG_POS = 4;
  localparam int         CC_W             = 4;
  localparam int         OUT_W            = 32;
  localparam int         COUNTER_WIDTH_DEF = 32;

  typedef logic [PID_W-1:0]      pid_t;
  typedef logic [CC_FIELD_W-1:0] cc_field_t;

  // Write port of the per-PID table.
  typedef struct packed {
    logic      en;
    pid_t      addr;
    cc_field_t data;
  } tbl_wr_t;

  // Outcome of one packet, handed to the statistics stage.
  typedef struct packed {
    logic valid;
    logic hdr_err;
    logic payload;
    logic cc_err;
  } pkt_event_t;

endpackage

/* src/tsc_hdr_if.sv */
// Channel carrying the first four header bytes of one packet.
// Depends on nothing.
`timescale 1ns / 1ps
interface tsc_hdr_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte_0;
  logic [7:0] header_byte_1;
  logic [7:0] header_byte_2;
  logic [7:0] header_byte_3;

  modport source (output valid, header_byte_0, header_byte_1, header_byte_2,
                  header_byte_3, input ready);
  modport sink (input valid, header_byte_0, header_byte_1, header_byte_2,
                header_byte_3, output ready);
endinterface

/* src/tsc_stat_if.sv */
// Channel carrying the per-packet statistics result.
// Depends on nothing.
`timescale 1ns / 1ps
interface tsc_stat_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_packets;
  logic [31:0] payload_packet_count;
  logic [31:0] header_error_count;
  logic [31:0] continuity_error_count;
  logic        this_header_error;
  logic        this_continuity_error;

  modport source (output valid, total_packets, payload_packet_count,
                  header_error_count, continuity_error_count, this_header_error,
                  this_continuity_error, input ready);
  modport sink (input valid, total_packets, payload_packet_count,
                header_error_count, continuity_error_count, this_header_error,
                this_continuity_error, output ready);
endinterface

/* src/tsc_pid_table.sv */
// Per-PID last continuity value table: one synchronous RAM with bypass.
// Depends on tsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
module tsc_pid_table
  import tsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      rd_en,
  input  pid_t      rd_addr,
  output cc_field_t rd_data,
  input  tbl_wr_t   wr,
  output logic      busy
);

  cc_field_t mem [TABLE_DEPTH];
  pid_t      clr_addr;

  // Clear sweep after reset, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + pid_t'(1);
      if (&clr_addr) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Forward a write landing on the same edge as the read of that entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.addr == rd_addr) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

`include "assert_macros.svh"
  `TSC_ASSERT_IMP(a_no_read_in_clear, clk, rst, busy, !rd_en)
  `TSC_ASSERT_IMP(a_no_write_in_clear, clk, rst, busy, !wr.en)
  `TSC_ASSERT_NXT(a_clear_advances, clk, rst, busy && !(&clr_addr),
                  busy && clr_addr == $past(clr_addr) + pid_t'(1))

endmodule

/* src/tsc_stats.sv */
// Wrapping packet counters and the result register of the checker.
// Depends on tsc_pkg, tsc_stat_if and assert_macros.svh.
`timescale 1ns / 1ps
module tsc_stats
  import tsc_pkg::*;
#(
  parameter int CNT_W = COUNTER_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  pkt_event_t ev,
  output logic       free,
  tsc_stat_if.source result
);

  logic [CNT_W-1:0] cnt_pkt, cnt_pay, cnt_hdr, cnt_cc;
  logic [CNT_W-1:0] cnt_pkt_next, cnt_pay_next, cnt_hdr_next, cnt_cc_next;

  assign free = !result.valid || result.ready;

  assign cnt_pkt_next = cnt_pkt + CNT_W'(1);
  assign cnt_pay_next = cnt_pay + CNT_W'(ev.payload);
  assign cnt_hdr_next = cnt_hdr + CNT_W'(ev.hdr_err);
  assign cnt_cc_next  = cnt_cc + CNT_W'(ev.cc_err);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_pkt      <= '0;
      cnt_pay      <= '0;
      cnt_hdr      <= '0;
      cnt_cc       <= '0;
      result.valid <= 1'b0;
    end else if (ev.valid) begin
      cnt_pkt      <= cnt_pkt_next;
      cnt_pay      <= cnt_pay_next;
      cnt_hdr      <= cnt_hdr_next;
      cnt_cc       <= cnt_cc_next;
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.valid) begin
      result.total_packets          <= OUT_W'(cnt_pkt_next);
      result.payload_packet_count   <= OUT_W'(cnt_pay_next);
      result.header_error_count     <= OUT_W'(cnt_hdr_next);
      result.continuity_error_count <= OUT_W'(cnt_cc_next);
      result.this_header_error      <= ev.hdr_err;
      result.this_continuity_error  <= ev.cc_err;
    end
  end

`include "assert_macros.svh"
  `TSC_ASSERT_IMP(a_event_only_when_free, clk, rst, ev.valid, free)
  `TSC_ASSERT_IMP(a_cc_err_is_payload, clk, rst, ev.valid && ev.cc_err,
                  ev.payload && !ev.hdr_err)
  `TSC_ASSERT_NXT(a_result_held, clk, rst, result.valid && !result.ready,
                  result.valid && $stable(result.total_packets))

endmodule

/* src/ts_continuity_checker.sv */
// Top level of the transport stream continuity checker.
// Depends on tsc_pkg, tsc_hdr_if, tsc_stat_if, tsc_pid_table, tsc_stats.
`timescale 1ns / 1ps
// Usage:
//   packet : sink channel, one beat per transport stream packet carrying its
//            first four header bytes.
//   result : source channel, one beat per packet with the four running
//            counts (taken after this packet) and this packet's error flags.
// Path: a taken packet beat is held in the check stage registers, and its
//   result beat is written into the result register as it leaves them.
// Throughput: one packet per cycle unless stalled. The per-PID table is a
//   single-port-write RAM with a registered read; the read for a packet is
//   issued as it is taken, and the write of the packet just ahead is
//   forwarded into that read, so back-to-back packets on one PID are exact.
// Reset: rst (synchronous) zeroes the counters and starts a clear sweep of
//   the 8192-entry table, one entry a cycle; packet.ready stays low until
//   the sweep has finished.
// Stall: while result is held, the finished beat waits in the result
//   register and one more packet is held in the check stage; the packet
//   channel then drops ready until the result beat is taken.
module ts_continuity_checker
  import tsc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tsc_hdr_if.sink    packet,
  tsc_stat_if.source result
);

  // Check stage registers.
  logic      s1_valid;
  logic      s1_hdr_err;
  logic      s1_payload;
  pid_t      s1_pid;
  cc_field_t s1_cc;

  logic       busy;
  logic       free;
  logic       accept;
  logic       advance;
  logic       hdr_ok;
  pid_t       in_pid;
  cc_field_t  stored;
  logic       cc_err;
  tbl_wr_t    tbl_wr;
  pkt_event_t ev;

  // Decode the incoming header.
  assign hdr_ok = packet.header_byte_0 == SYNC_BYTE && !packet.header_byte_1[ERR_BIT_POS];
  assign in_pid = {packet.header_byte_1[PID_W-9:0], packet.header_byte_2};

  assign advance      = s1_valid && free;
  assign packet.ready = !busy && (!s1_valid || free);
  assign accept       = packet.valid && packet.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hdr_err <= !hdr_ok;
      s1_payload <= hdr_ok && in_pid != NULL_PID;
      s1_pid     <= in_pid;
      s1_cc      <= packet.header_byte_3[CC_FIELD_W-1:0];
    end
  end

  // Check against the stored value: only when both values are nonzero and
  // the payload flag is set must the counter step by one.
  assign cc_err = s1_payload && s1_cc != '0 && stored != '0 &&
                  s1_cc[PAYLOAD_FLAG_POS] &&
                  (stored[CC_W-1:0] + CC_W'(1)) != s1_cc[CC_W-1:0];

  // Store a nonzero value as the packet leaves the check stage.
  assign tbl_wr.en   = advance && s1_payload && s1_cc != '0;
  assign tbl_wr.addr = s1_pid;
  assign tbl_wr.data = s1_cc;

  tsc_pid_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_pid),
    .rd_data (stored),
    .wr      (tbl_wr),
    .busy    (busy)
  );

  assign ev.valid   = advance;
  assign ev.hdr_err = s1_hdr_err;
  assign ev.payload = s1_payload;
  assign ev.cc_err  = cc_err;

  tsc_stats #(
    .CNT_W (COUNTER_WIDTH)
  ) u_stats (
    .clk    (clk),
    .rst    (rst),
    .ev     (ev),
    .free   (free),
    .result (result)
  );

endmodule
